[rtl/mtfo_pkg.sv]
// shared constants, types and the twist-and-temper function for the seed-to-outputs block
package mtfo_pkg;

  localparam int unsigned LAST_INDEX = 398;
  localparam int unsigned FAR_INDEX  = 397;

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  // values that ride along the chain next to the running element
  typedef struct packed {
    logic        e0_msb;
    logic [31:0] e1;
    logic [30:0] e2_low;
    logic [31:0] first;
  } side_t;

  // twist of one element followed by the standard tempering
  function automatic logic [31:0] twist_temper(input logic a_msb, input logic [30:0] b_low,
                                               input logic [31:0] c);
    logic [31:0] y;
    logic [31:0] v;
    y = ({a_msb, 31'd0} & UPPER_MASK) | ({1'b0, b_low} & LOWER_MASK);
    v = c ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

[rtl/mtfo_cell.sv]
// one step of the initialization recurrence, registered, with side data passed along
module mtfo_cell import mtfo_pkg::*; #(
  parameter int unsigned IDX = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        valid_in,
  input  logic [31:0] cur_in,
  input  side_t       side_in,
  output logic        valid_out,
  output logic [31:0] cur_out,
  output side_t       side_out
);

  logic        valid_r;
  logic [31:0] cur_r;
  logic [31:0] cur_nxt;
  side_t       side_r;
  logic [31:0] mixed;

  assign mixed   = cur_in ^ (cur_in >> 30);
  // product kept to 32 bits, the recurrence is mod 2^32
  assign cur_nxt = mixed * INIT_MULT + 32'(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_r  <= cur_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign cur_out   = cur_r;
  assign side_out  = side_r;

endmodule

[rtl/mt19937_first_two_outputs.sv]
// Seed to first two tempered outputs: a request passes through the 398 recurrence cells
// (one multiply-add each) and then the output register.
// Throughput: one seed per cycle; the whole chain advances together and holds
// while a finished result waits on out_ready.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module mt19937_first_two_outputs import mtfo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_first_output,
  output logic [31:0] out_second_output
);

  localparam int unsigned NCELL = LAST_INDEX;

  logic        adv;
  logic        out_valid_r;
  logic [31:0] first_r;
  logic [31:0] second_r;

  logic        v_chain    [NCELL+1];
  logic [31:0] cur_chain  [NCELL+1];
  side_t       side_chain [NCELL+1];

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign v_chain[0]           = in_valid;
  assign cur_chain[0]         = in_seed_value;
  assign side_chain[0].e0_msb = in_seed_value[31];
  assign side_chain[0].e1     = '0;
  assign side_chain[0].e2_low = '0;
  assign side_chain[0].first  = '0;

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    side_t side_in;

    // pick up e1, e2 and e397 as they leave their cells
    always_comb begin
      side_in = side_chain[k-1];
      if (k == 2) begin
        side_in.e1 = cur_chain[k-1];
      end
      if (k == 3) begin
        side_in.e2_low = cur_chain[k-1][30:0];
      end
      if (k == NCELL) begin
        side_in.first = twist_temper(side_chain[k-1].e0_msb, side_chain[k-1].e1[30:0],
                                     cur_chain[k-1]);
      end
    end

    mtfo_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .valid_in (v_chain[k-1]),
      .cur_in   (cur_chain[k-1]),
      .side_in  (side_in),
      .valid_out(v_chain[k]),
      .cur_out  (cur_chain[k]),
      .side_out (side_chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_chain[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= side_chain[NCELL].first;
      second_r <= twist_temper(side_chain[NCELL].e1[31], side_chain[NCELL].e2_low,
                               cur_chain[NCELL]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_output  = first_r;
  assign out_second_output = second_r;

endmodule

[rtl/mtfo_checker.sv]
// port-level checks for the seed-to-outputs block, bound to the top level
module mtfo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_first_output,
  input logic [31:0] out_second_output
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a waiting result keeps both words
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_output) && $stable(out_second_output))
    else $error("result changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // an empty output slot never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // a stalled result freezes the whole chain
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while the chain is stalled");

endmodule

bind mt19937_first_two_outputs mtfo_checker u_mtfo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_first_output (out_first_output),
  .out_second_output(out_second_output)
);
